// File: sv/ppcm_pkg.sv
package ppcm_pkg;

	// Fixed sizes of the command mux.
	localparam int NUM_SOURCES = 4;
	localparam int SRC_W       = 2;
	localparam int OWN_W       = SRC_W + 1;
	localparam int WORD_BITS   = 32;
	localparam int PRIO_W      = 8;
	localparam int TMO_W       = 16;
	localparam int GLB_W       = TMO_W + 1;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 64;

	// Owner code for a channel that nobody holds.
	localparam logic [OWN_W-1:0] VACANT = OWN_W'(4);

	// Item kinds.
	localparam logic [1:0] KIND_ANGLE = 2'd0;
	localparam logic [1:0] KIND_SPEED = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// Register indexes, taken from paddr[4:3].
	localparam logic [1:0] REG_ANGLE_PRIO = 2'd0;
	localparam logic [1:0] REG_ANGLE_TMO  = 2'd1;
	localparam logic [1:0] REG_SPEED_PRIO = 2'd2;
	localparam logic [1:0] REG_SPEED_TMO  = 2'd3;

	// What a channel reports about the item it is looking at.
	typedef struct packed {
		logic             grant;
		logic             changed;
		logic             idle;
		logic [OWN_W-1:0] last;
	} chan_stat_t;

	// Longest of the four packed timeouts.
	function automatic logic [TMO_W-1:0] longest_tmo(input logic [DATA_W-1:0] tmo);
		logic [TMO_W-1:0] m01;
		logic [TMO_W-1:0] m23;
		m01 = (tmo[15:0] > tmo[31:16]) ? tmo[15:0] : tmo[31:16];
		m23 = (tmo[47:32] > tmo[63:48]) ? tmo[47:32] : tmo[63:48];
		return (m01 > m23) ? m01 : m23;
	endfunction

endpackage

// File: sv/ppcm_chan.sv
module ppcm_chan (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic                               tick,
	input  logic                               cmd,
	input  logic [ppcm_pkg::SRC_W-1:0]          src,
	input  logic [31:0]                        prio,
	input  logic [ppcm_pkg::DATA_W-1:0]         tmo,
	input  logic [ppcm_pkg::TMO_W-1:0]          longest,
	output ppcm_pkg::chan_stat_t               stat
);
	import ppcm_pkg::*;

	logic [OWN_W-1:0]       owner_q;
	logic [OWN_W-1:0]       last_q;
	logic [NUM_SOURCES-1:0] src_run_q;
	logic [TMO_W-1:0]       src_rem_q [NUM_SOURCES];
	logic                   glb_run_q;
	logic [GLB_W-1:0]       glb_rem_q;

	logic [TMO_W-1:0]       src_dec [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] src_exp;
	logic [GLB_W-1:0]       glb_dec;
	logic                   glb_exp;
	logic [SRC_W-1:0]       own_idx;
	logic                   src_hit;
	logic                   glb_hit;
	logic [PRIO_W-1:0]      src_prio;
	logic [PRIO_W-1:0]      own_prio;
	logic                   grant;

	// Countdown of every running timer on a tick; reaching zero is an expiry.
	always_comb begin
		for (int i = 0; i < NUM_SOURCES; i++) begin
			src_dec[i] = (src_rem_q[i] == '0) ? '0 : src_rem_q[i] - 1'b1;
			src_exp[i] = src_run_q[i] && (src_dec[i] == '0);
		end
		glb_dec = (glb_rem_q == '0) ? '0 : glb_rem_q - 1'b1;
		glb_exp = glb_run_q && (glb_dec == '0);
	end

	// The owner is vacated by its own timer first, else by the channel timer.
	assign own_idx = owner_q[SRC_W-1:0];
	assign src_hit = (owner_q != VACANT) && src_exp[own_idx];
	assign glb_hit = glb_exp && !src_hit && (owner_q != VACANT);

	// Grant when vacant, already owned, or strictly higher priority.
	assign src_prio = prio[{src, 3'b000} +: PRIO_W];
	assign own_prio = prio[{own_idx, 3'b000} +: PRIO_W];
	assign grant = (owner_q == VACANT) || (owner_q == {1'b0, src}) || (src_prio > own_prio);

	assign stat.grant   = cmd && grant;
	assign stat.changed = cmd && grant && (owner_q != {1'b0, src});
	assign stat.idle    = tick && (src_hit || glb_hit);
	assign stat.last    = last_q;

	// Channel state update, one item per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q   <= VACANT;
			last_q    <= VACANT;
			src_run_q <= '0;
			glb_run_q <= 1'b0;
			glb_rem_q <= '0;
			for (int i = 0; i < NUM_SOURCES; i++) begin
				src_rem_q[i] <= '0;
			end
		end else if (step && tick) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				if (src_run_q[i]) begin
					src_run_q[i] <= !src_exp[i];
					src_rem_q[i] <= src_dec[i];
				end
			end
			if (glb_run_q) begin
				glb_run_q <= !glb_exp;
				glb_rem_q <= glb_dec;
			end
			if (src_hit || glb_hit) begin
				owner_q <= VACANT;
			end
		end else if (step && cmd) begin
			glb_run_q      <= 1'b1;
			glb_rem_q      <= {longest, 1'b0};
			src_run_q[src] <= 1'b1;
			src_rem_q[src] <= tmo[{src, 4'b0000} +: TMO_W];
			if (grant) begin
				owner_q <= {1'b0, src};
				last_q  <= {1'b0, src};
			end
		end
	end

endmodule

// File: sv/paired_priority_command_mux.sv
// Paired priority command mux.
// Input stream: s_tuser holds the item kind (angle command, speed command or
// tick), s_tdata holds the source index and the 32-bit command word. Every
// accepted beat gives exactly one output beat: m_tuser carries the forward,
// channel, announce and idle flags, m_tdata the forwarded word and the
// announced source.
// Each channel grants a command to its source when the channel is vacant,
// already held by that source, or the source outranks the owner. A command is
// forwarded only when both channels last granted the same source. Ticks count
// per-source and per-channel timers down and vacate owners on expiry.
// A beat goes through one input register, then a single pass of compare and
// counter logic into the output register.
// One beat is accepted every cycle; a stalled receiver holds the output
// register, and the input register then fills and drops s_tready.
// Reset clears all owners to vacant, stops all timers and zeroes the
// configuration registers. The APB port writes priorities and timeouts at byte addresses
// 0, 8, 16 and 24; it is to be written only while no beat is in flight.
module paired_priority_command_mux (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppcm_pkg::ADDR_W-1:0]    paddr,
	input  logic [ppcm_pkg::DATA_W-1:0]    pwdata,
	output logic [ppcm_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,  // source[1:0], command_word[33:2], zeros
	input  logic [1:0]                    s_tuser,  // kind[1:0]
	// Output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,  // forward_word[31:0], announce_source[33:32], zeros
	output logic [3:0]                    m_tuser   // forward_valid, forward_channel,
	                                                // announce_valid, idle_announce
);
	import ppcm_pkg::*;

	// Configuration registers
	logic [31:0]       angle_prio_q;
	logic [DATA_W-1:0] angle_tmo_q;
	logic [31:0]       speed_prio_q;
	logic [DATA_W-1:0] speed_tmo_q;
	logic [TMO_W-1:0]  angle_longest_q;
	logic [TMO_W-1:0]  speed_longest_q;
	logic              cfg_wr;

	// Input register
	logic                 valid_s1;
	logic [1:0]           kind_s1;
	logic [SRC_W-1:0]     src_s1;
	logic [WORD_BITS-1:0] word_s1;

	// Output register
	logic                 m_valid_q;
	logic                 fwd_q;
	logic                 fwd_ch_q;
	logic [WORD_BITS-1:0] fwd_word_q;
	logic                 ann_q;
	logic [SRC_W-1:0]     ann_src_q;
	logic                 idle_q;

	logic              announce_pending_q;
	logic              advance;
	logic              is_tick;
	logic              is_angle;
	logic              is_speed;
	chan_stat_t        angle_stat;
	chan_stat_t        speed_stat;
	chan_stat_t        cur_stat;
	logic [OWN_W-1:0]  other_last;
	logic              granted;
	logic              pending_now;
	logic              fwd;
	logic              ann;
	logic              idle;

	// Register writes; the longest timeout of each channel is kept alongside.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_prio_q    <= '0;
			angle_tmo_q     <= '0;
			speed_prio_q    <= '0;
			speed_tmo_q     <= '0;
			angle_longest_q <= '0;
			speed_longest_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_ANGLE_PRIO: angle_prio_q <= pwdata[31:0];
				REG_ANGLE_TMO: begin
					angle_tmo_q     <= pwdata;
					angle_longest_q <= longest_tmo(pwdata);
				end
				REG_SPEED_PRIO: speed_prio_q <= pwdata[31:0];
				REG_SPEED_TMO: begin
					speed_tmo_q     <= pwdata;
					speed_longest_q <= longest_tmo(pwdata);
				end
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[4:3])
			REG_ANGLE_PRIO: prdata = {32'd0, angle_prio_q};
			REG_ANGLE_TMO:  prdata = angle_tmo_q;
			REG_SPEED_PRIO: prdata = {32'd0, speed_prio_q};
			REG_SPEED_TMO:  prdata = speed_tmo_q;
			default:        prdata = '0;
		endcase
	end

	// Handshake: the input register moves on when the output register is free.
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			src_s1  <= s_tdata[1:0];
			word_s1 <= s_tdata[33:2];
		end
	end

	assign is_tick  = (kind_s1 == KIND_TICK);
	assign is_angle = (kind_s1 == KIND_ANGLE);
	assign is_speed = (kind_s1 == KIND_SPEED);

	ppcm_chan u_angle (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.tick    (is_tick),
		.cmd     (is_angle),
		.src     (src_s1),
		.prio    (angle_prio_q),
		.tmo     (angle_tmo_q),
		.longest (angle_longest_q),
		.stat    (angle_stat)
	);

	ppcm_chan u_speed (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.tick    (is_tick),
		.cmd     (is_speed),
		.src     (src_s1),
		.prio    (speed_prio_q),
		.tmo     (speed_tmo_q),
		.longest (speed_longest_q),
		.stat    (speed_stat)
	);

	// Forward only when the other channel last granted the same source.
	assign cur_stat    = is_speed ? speed_stat : angle_stat;
	assign other_last  = is_speed ? angle_stat.last : speed_stat.last;
	assign granted     = cur_stat.grant;
	assign pending_now = announce_pending_q || cur_stat.changed;
	assign fwd         = granted && (other_last == {1'b0, src_s1});
	assign ann         = fwd && pending_now;
	assign idle        = angle_stat.idle || speed_stat.idle;

	// Pending announcement of a new owner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			announce_pending_q <= 1'b0;
		end else if (advance && granted) begin
			announce_pending_q <= fwd ? 1'b0 : pending_now;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_q      <= fwd;
			fwd_ch_q   <= fwd && is_speed;
			fwd_word_q <= fwd ? word_s1 : '0;
			ann_q      <= ann;
			ann_src_q  <= ann ? src_s1 : '0;
			idle_q     <= is_tick && idle;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, ann_src_q, fwd_word_q};
	assign m_tuser  = {idle_q, ann_q, fwd_ch_q, fwd_q};

	// An announcement always rides on a forwarded command.
	a_ann_with_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[2] && !m_tuser[0]))
		else $error("announce without forwarded command");

	// Idle is only reported for ticks, never with a forwarded command.
	a_idle_not_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[3] && m_tuser[0]))
		else $error("idle reported with a forwarded command");

	// A forwarded command leaves no announcement pending.
	a_pending_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fwd) |=> !announce_pending_q)
		else $error("announcement still pending after forward");

endmodule
